[design/gwm_pkg.sv]
// Shared types and constants for the glob wildcard matcher.
// Used by gwm_front, gwm_back and glob_wildcard_matcher_unit; depends on nothing.
package gwm_pkg;

    // Default number of pattern entries.
    localparam int PATTERN_MAX_DEF = 32;

    // Width of the pattern length register.
    localparam int CFG_W = 6;

    // Depths of the command queue and the result queue.
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // Function codes on the input channel.
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_CHAR = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    // Pattern entry kinds.
    localparam logic [2:0] KIND_LITERAL = 3'd0;
    localparam logic [2:0] KIND_ANY     = 3'd1;
    localparam logic [2:0] KIND_DIGIT   = 3'd2;
    localparam logic [2:0] KIND_LOWER   = 3'd3;
    localparam logic [2:0] KIND_UPPER   = 3'd4;
    localparam logic [2:0] KIND_STAR    = 3'd5;

    // Character class bounds.
    localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
    localparam logic [7:0] CHAR_LOWER_LO = 8'h61;
    localparam logic [7:0] CHAR_LOWER_HI = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
    localparam logic [7:0] CHAR_UPPER_HI = 8'h5A;

    // Operation carried from the front part to the back part.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_CHAR,
        OP_END
    } op_t;

    // One classified command in the command queue.
    typedef struct packed {
        op_t        op;
        logic [4:0] idx;
        logic [2:0] kind;
        logic [7:0] data;
        logic       is_digit;
        logic       is_lower;
        logic       is_upper;
    } cmd_t;

endpackage

[design/gwm_fifo.sv]
// Small synchronous first-in first-out queue of generic width.
// Stands between the front and back parts and holds results; no package use.
module gwm_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    // Status flags and read port.
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage is payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/gwm_front.sv]
// Front part: accepts input transactions, drops those with no effect and
// classifies test characters. Depends on gwm_pkg.
module gwm_front #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
    input  logic          push,
    output logic          full,
    input  logic [1:0]    func,
    input  logic [4:0]    entry_index,
    input  logic [2:0]    entry_kind,
    input  logic [7:0]    entry_byte,
    input  logic [7:0]    test_char,
    input  logic          cmd_full,
    output logic          cmd_push,
    output gwm_pkg::cmd_t cmd
);

    logic keep;

    assign full = cmd_full;

    // Decode the function and build the command for the back part.
    always_comb
    begin
        keep         = 1'b0;
        cmd.op       = gwm_pkg::OP_CHAR;
        cmd.idx      = entry_index;
        cmd.kind     = entry_kind;
        cmd.data     = test_char;
        cmd.is_digit = (test_char >= gwm_pkg::CHAR_DIGIT_LO)
                       && (test_char <= gwm_pkg::CHAR_DIGIT_HI);
        cmd.is_lower = (test_char >= gwm_pkg::CHAR_LOWER_LO)
                       && (test_char <= gwm_pkg::CHAR_LOWER_HI);
        cmd.is_upper = (test_char >= gwm_pkg::CHAR_UPPER_LO)
                       && (test_char <= gwm_pkg::CHAR_UPPER_HI);
        case (func)
            gwm_pkg::FUNC_LOAD:
            begin
                // Loads beyond the pattern store are dropped.
                keep     = (int'(entry_index) < PATTERN_MAX);
                cmd.op   = gwm_pkg::OP_LOAD;
                cmd.data = entry_byte;
            end
            gwm_pkg::FUNC_CHAR:
            begin
                keep   = 1'b1;
                cmd.op = gwm_pkg::OP_CHAR;
            end
            gwm_pkg::FUNC_END:
            begin
                keep   = 1'b1;
                cmd.op = gwm_pkg::OP_END;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign cmd_push = push && !cmd_full && keep;

endmodule

[design/gwm_back.sv]
// Back part: holds pattern, active position set and length register; runs
// one command per cycle unless an end finds res_full. Depends on gwm_pkg.
module gwm_back #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [gwm_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      cmd_empty,
    input  gwm_pkg::cmd_t             cmd,
    output logic                      cmd_pop,
    input  logic                      res_full,
    output logic                      res_push,
    output logic                      res_matched
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int LVL   = $clog2(PATTERN_MAX + 1);

    logic [2:0]                kind_reg [PATTERN_MAX];
    logic [7:0]                byte_reg [PATTERN_MAX];
    logic [PATTERN_MAX:0]      active_reg;
    logic [PATTERN_MAX:0]      active_next;
    logic                      saw_reg;
    logic                      saw_next;
    logic [gwm_pkg::CFG_W-1:0] plen_reg;
    logic [LEN_W-1:0]          used_len;
    logic [PATTERN_MAX-1:0]    in_len;
    logic [PATTERN_MAX-1:0]    is_star;
    logic [PATTERN_MAX-1:0]    accepts;
    logic [PATTERN_MAX:0]      cur;
    logic [PATTERN_MAX:0]      step;
    logic                      match;
    logic                      exec;

    // Clamp the length register to the store size.
    always_comb
    begin
        if ({1'b0, plen_reg} > 7'(PATTERN_MAX))
        begin
            used_len = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            used_len = LEN_W'(plen_reg);
        end
    end

    // Per-entry decode: in use, star, and whether it takes the character.
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            in_len[i]  = (LEN_W'(i) < used_len);
            is_star[i] = (kind_reg[i] == gwm_pkg::KIND_STAR);
            case (kind_reg[i])
                gwm_pkg::KIND_LITERAL: accepts[i] = (cmd.data == byte_reg[i]);
                gwm_pkg::KIND_ANY:     accepts[i] = 1'b1;
                gwm_pkg::KIND_DIGIT:   accepts[i] = cmd.is_digit;
                gwm_pkg::KIND_LOWER:   accepts[i] = cmd.is_lower;
                gwm_pkg::KIND_UPPER:   accepts[i] = cmd.is_upper;
                default:               accepts[i] = 1'b0;
            endcase
        end
    end

    // Star closure as a parallel prefix: an active position flows forward
    // through every run of stars inside the used length.
    always_comb
    begin
        logic [PATTERN_MAX:0] g;
        logic [PATTERN_MAX:0] t;
        logic [PATTERN_MAX:0] g_n;
        logic [PATTERN_MAX:0] t_n;
        g    = active_reg;
        t[0] = 1'b0;
        for (int j = 1; j <= PATTERN_MAX; j++)
        begin
            t[j] = is_star[j-1] && in_len[j-1];
        end
        for (int l = 0; l < LVL; l++)
        begin
            g_n = g;
            t_n = t;
            for (int j = (1 << l); j <= PATTERN_MAX; j++)
            begin
                g_n[j] = g[j] || (t[j] && g[j - (1 << l)]);
                t_n[j] = t[j] && t[j - (1 << l)];
            end
            g = g_n;
            t = t_n;
        end
        cur = g;
    end

    // Position update for one test character.
    always_comb
    begin
        step = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (cur[i] && in_len[i])
            begin
                if (is_star[i])
                begin
                    step[i] = 1'b1;
                end
                else if (accepts[i])
                begin
                    step[i+1] = 1'b1;
                end
            end
        end
    end

    // An empty pattern always matches; otherwise a character must have been
    // seen and the end position must be reachable.
    assign match = (used_len == '0) || (saw_reg && cur[used_len]);

    // A command runs unless it is an end and the result queue is full.
    assign exec        = !cmd_empty && ((cmd.op != gwm_pkg::OP_END) || !res_full);
    assign cmd_pop     = exec;
    assign res_push    = exec && (cmd.op == gwm_pkg::OP_END);
    assign res_matched = match;

    // Next state of the active set.
    always_comb
    begin
        active_next = active_reg;
        saw_next    = saw_reg;
        if (exec)
        begin
            case (cmd.op)
                gwm_pkg::OP_CHAR:
                begin
                    active_next = step;
                    saw_next    = 1'b1;
                end
                gwm_pkg::OP_END:
                begin
                    active_next = (PATTERN_MAX + 1)'(1);
                    saw_next    = 1'b0;
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= (PATTERN_MAX + 1)'(1);
            saw_reg    <= 1'b0;
            plen_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            saw_reg    <= saw_next;
            if (cfg_wr_en)
            begin
                plen_reg <= cfg_wr_data;
            end
        end
    end

    // Pattern store; entries hold no reset value.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (exec && (cmd.op == gwm_pkg::OP_LOAD) && (int'(cmd.idx) == i))
            begin
                kind_reg[i] <= cmd.kind;
                byte_reg[i] <= cmd.data;
            end
        end
    end

endmodule

[design/glob_wildcard_matcher_unit.sv]
// Glob wildcard matcher, top level.
// Holds the front part, the command queue, the back part and the result
// queue. Depends on gwm_pkg, gwm_front, gwm_fifo and gwm_back.
//
// Usage: the input side is a queue. A transaction is taken when push is high
// and full is low. func selects a pattern load (entry_index, entry_kind,
// entry_byte), a test character (test_char) or the end of a test string.
// Only an end transaction gives a result; matched waits on the output queue
// while empty is low and leaves it when pop is high.
// cfg_wr_en with cfg_wr_data writes pattern_length at once; write it only
// while no transaction is in flight.
// Throughput: one transaction per cycle while the receiver keeps up. Each
// test character updates all pattern positions in parallel in the back part.
// The result of an end transaction is registered in the command queue and
// then in the result queue before it shows on matched.
// Reset empties both queues, clears pattern_length and leaves only position
// zero active; the pattern entries stay undefined until loaded.
// When the receiver stalls, the two-entry result queue fills, end commands
// then wait in the four-entry command queue, and full rises when it fills.
module glob_wildcard_matcher_unit #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                func,
    input  logic [4:0]                entry_index,
    input  logic [2:0]                entry_kind,
    input  logic [7:0]                entry_byte,
    input  logic [7:0]                test_char,
    output logic                      empty,
    input  logic                      pop,
    output logic                      matched,
    input  logic                      cfg_wr_en,
    input  logic [gwm_pkg::CFG_W-1:0] cfg_wr_data
);

    localparam int CMD_W = $bits(gwm_pkg::cmd_t);

    gwm_pkg::cmd_t front_cmd;
    gwm_pkg::cmd_t back_cmd;
    logic [CMD_W-1:0] back_cmd_bits;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;
    logic          res_push;
    logic          res_full;
    logic          res_matched;

    // Accept and classify input transactions.
    gwm_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .push        (push),
        .full        (full),
        .func        (func),
        .entry_index (entry_index),
        .entry_kind  (entry_kind),
        .entry_byte  (entry_byte),
        .test_char   (test_char),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd         (front_cmd)
    );

    // Command queue between the front and back parts.
    gwm_fifo #(
        .DEPTH (gwm_pkg::CMD_DEPTH),
        .WIDTH (CMD_W)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd_bits),
        .empty   (cmd_empty)
    );

    assign back_cmd = gwm_pkg::cmd_t'(back_cmd_bits);

    // Pattern matching engine.
    gwm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_empty   (cmd_empty),
        .cmd         (back_cmd),
        .cmd_pop     (cmd_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_matched (res_matched)
    );

    // Result queue toward the receiver.
    gwm_fifo #(
        .DEPTH (gwm_pkg::RES_DEPTH),
        .WIDTH (1)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_matched),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (matched),
        .empty   (empty)
    );

endmodule
